@@ src/srs_pkg.sv @@
`default_nettype none

package srs_pkg;

  // Largest byte count that a start item may ask for.
  localparam logic [3:0] MAX_BYTES = 4'd4;

  // Operation codes of an input item.
  localparam logic [1:0] OP_START    = 2'd0;
  localparam logic [1:0] OP_TX_READY = 2'd1;
  localparam logic [1:0] OP_RX_BYTE  = 2'd2;
  localparam logic [1:0] OP_TX_DONE  = 2'd3;

  // Status codes of a result item.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_FAULT   = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic        is_read;
    logic [2:0]  byte_count;
    logic [6:0]  reg_addr;
    logic [31:0] wr_data;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        done_res;
    logic [31:0] read_data;
    logic        busy_res;
    logic [1:0]  status;
  } result_t;

endpackage

`default_nettype wire

@@ src/srs_if.sv @@
`default_nettype none

interface srs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic        is_read;
  logic [2:0]  byte_count;
  logic [6:0]  reg_addr;
  logic [31:0] wr_data;
  logic [7:0]  rx_byte;

  modport source (output valid, op, is_read, byte_count, reg_addr, wr_data, rx_byte,
                  input ready);
  modport sink (input valid, op, is_read, byte_count, reg_addr, wr_data, rx_byte,
                output ready);
endinterface

interface srs_out_if;
  logic        valid;
  logic        ready;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        done_res;
  logic [31:0] read_data;
  logic        busy_res;
  logic [1:0]  status;

  modport source (output valid, tx_valid, tx_byte, done_res, read_data, busy_res, status,
                  input ready);
  modport sink (input valid, tx_valid, tx_byte, done_res, read_data, busy_res, status,
                output ready);
endinterface

interface srs_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

@@ src/srs_core.sv @@
`default_nettype none

module srs_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             item_valid,
  input  wire srs_pkg::in_item_t item,
  input  wire logic             cfg_we,
  input  wire logic [7:0]       cfg_data,
  output srs_pkg::result_t      res
);

  typedef enum logic [1:0] {PH_IDLE, PH_ADDR, PH_READ, PH_WRITE} phase_t;

  phase_t      phase_r, phase_nxt;
  logic        read_mode_r, read_mode_nxt;
  logic [6:0]  addr_r, addr_nxt;
  logic [31:0] wword_r, wword_nxt;
  logic [2:0]  tx_rem_r, tx_rem_nxt;
  logic [2:0]  rx_rem_r, rx_rem_nxt;
  logic        skip_rx_r, skip_rx_nxt;
  logic [31:0] accum_r, accum_nxt;
  logic        txr_en_r, txr_en_nxt;
  logic        txc_en_r, txc_en_nxt;
  logic [7:0]  fill_r;

  logic [2:0]  tx_dec;
  logic [2:0]  rx_dec;
  logic        bad_start;

  assign tx_dec    = tx_rem_r - 3'd1;
  assign rx_dec    = rx_rem_r - 3'd1;
  assign bad_start = (phase_r != PH_IDLE) || (item.byte_count == 3'd0) ||
                     ({1'b0, item.byte_count} > srs_pkg::MAX_BYTES);

  always_comb begin
    phase_nxt     = phase_r;
    read_mode_nxt = read_mode_r;
    addr_nxt      = addr_r;
    wword_nxt     = wword_r;
    tx_rem_nxt    = tx_rem_r;
    rx_rem_nxt    = rx_rem_r;
    skip_rx_nxt   = skip_rx_r;
    accum_nxt     = accum_r;
    txr_en_nxt    = txr_en_r;
    txc_en_nxt    = txc_en_r;
    res.tx_valid  = 1'b0;
    res.tx_byte   = 8'd0;
    res.done_res  = 1'b0;
    res.status    = srs_pkg::ST_OK;

    if (item.op == srs_pkg::OP_START) begin
      if (bad_start) begin
        res.status = srs_pkg::ST_FAULT;
      end else begin
        read_mode_nxt = item.is_read;
        addr_nxt      = item.reg_addr;
        wword_nxt     = item.wr_data;
        tx_rem_nxt    = item.byte_count;
        rx_rem_nxt    = item.byte_count;
        skip_rx_nxt   = 1'b1;
        accum_nxt     = 32'd0;
        phase_nxt     = PH_ADDR;
        txr_en_nxt    = 1'b1;
        txc_en_nxt    = 1'b0;
      end
    end else if (phase_r == PH_IDLE) begin
      res.status = srs_pkg::ST_IGNORED;
    end else begin
      case (item.op)
        srs_pkg::OP_TX_READY: begin
          if (!txr_en_r) begin
            res.status = srs_pkg::ST_IGNORED;
          end else if (phase_r == PH_ADDR) begin
            res.tx_valid = 1'b1;
            res.tx_byte  = {read_mode_r, addr_r};
            phase_nxt    = read_mode_r ? PH_READ : PH_WRITE;
          end else if (tx_rem_r == 3'd0) begin
            txr_en_nxt = 1'b0;
            res.status = srs_pkg::ST_FAULT;
          end else if (phase_r == PH_READ) begin
            res.tx_valid = 1'b1;
            res.tx_byte  = fill_r;
            tx_rem_nxt   = tx_dec;
            if (tx_dec == 3'd0) begin
              txr_en_nxt = 1'b0;
            end
          end else begin
            // Bytes beyond the 32-bit word come out as zero.
            tx_rem_nxt   = tx_dec;
            res.tx_valid = 1'b1;
            res.tx_byte  = tx_dec[2] ? 8'd0 : wword_r[{tx_dec[1:0], 3'b000} +: 8];
            if (tx_dec == 3'd0) begin
              txr_en_nxt = 1'b0;
              txc_en_nxt = 1'b1;
            end
          end
        end
        srs_pkg::OP_RX_BYTE: begin
          if (phase_r == PH_ADDR) begin
            res.status = srs_pkg::ST_FAULT;
          end else if (phase_r == PH_READ) begin
            if (skip_rx_r) begin
              skip_rx_nxt = 1'b0;
            end else if (rx_rem_r == 3'd0) begin
              res.status = srs_pkg::ST_FAULT;
            end else begin
              rx_rem_nxt = rx_dec;
              if (!rx_dec[2]) begin
                accum_nxt = accum_r | ({24'd0, item.rx_byte} << {rx_dec[1:0], 3'b000});
              end
              if (rx_dec == 3'd0) begin
                res.done_res = 1'b1;
                phase_nxt    = PH_IDLE;
                txr_en_nxt   = 1'b0;
                txc_en_nxt   = 1'b0;
              end
            end
          end
        end
        srs_pkg::OP_TX_DONE: begin
          if (!txc_en_r) begin
            res.status = srs_pkg::ST_IGNORED;
          end else if (phase_r == PH_WRITE) begin
            res.done_res = 1'b1;
            phase_nxt    = PH_IDLE;
            txr_en_nxt   = 1'b0;
            txc_en_nxt   = 1'b0;
          end else begin
            txc_en_nxt = 1'b0;
            res.status = srs_pkg::ST_FAULT;
          end
        end
        default: begin
          res.status = srs_pkg::ST_FAULT;
        end
      endcase
    end

    res.read_data = accum_nxt;
    res.busy_res  = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      read_mode_r <= 1'b0;
      accum_r     <= 32'd0;
      txr_en_r    <= 1'b0;
      txc_en_r    <= 1'b0;
      fill_r      <= 8'd0;
    end else begin
      if (item_valid) begin
        phase_r     <= phase_nxt;
        read_mode_r <= read_mode_nxt;
        accum_r     <= accum_nxt;
        txr_en_r    <= txr_en_nxt;
        txc_en_r    <= txc_en_nxt;
      end
      if (cfg_we) begin
        fill_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r    <= 7'd0;
      wword_r   <= 32'd0;
      tx_rem_r  <= 3'd0;
      rx_rem_r  <= 3'd0;
      skip_rx_r <= 1'b0;
    end else if (item_valid) begin
      addr_r    <= addr_nxt;
      wword_r   <= wword_nxt;
      tx_rem_r  <= tx_rem_nxt;
      rx_rem_r  <= rx_rem_nxt;
      skip_rx_r <= skip_rx_nxt;
    end
  end

  a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid && res.done_res) |=> (phase_r == PH_IDLE && !txr_en_r && !txc_en_r))
    else $error("transaction completed but sequencer did not return to idle");

  a_idle_no_enables: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (!txr_en_r && !txc_en_r))
    else $error("event enable left set while idle");

  a_tx_only_on_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid && res.tx_valid) |-> (item.op == srs_pkg::OP_TX_READY))
    else $error("transmit byte produced by an event other than transmit ready");

endmodule

`default_nettype wire

@@ src/spi_register_access_sequencer.sv @@
`default_nettype none

// Channel   Direction  Handshake                    Item carried
// in_chan   sink       in_chan.valid/in_chan.ready  op, is_read, byte_count, reg_addr,
//                                                    wr_data, rx_byte
// out_chan  source     out_chan.valid/out_chan.ready tx_valid, tx_byte, done_res,
//                                                    read_data, busy_res, status
// cfg_chan  sink       cfg_chan.valid/cfg_chan.ready fill byte (data)
//
// Every input item yields exactly one result item, presented the cycle after it is
// accepted unless the output is stalled, in which case it waits in order.
// The sequencer state is updated at the accepting edge, so one item per cycle is sustained
// unless the output stalls. A skid register behind the result register keeps in_chan.ready
// high as an output stall begins; ready drops only while the skid register holds an item.
// rst_n is synchronous and active low; it clears the sequencer to idle and the fill byte to 0.
// The configuration channel is always ready and takes effect on the following item.

module spi_register_access_sequencer (
  input wire logic clk,
  input wire logic rst_n,
  srs_in_if.sink   in_chan,
  srs_out_if.source out_chan,
  srs_cfg_if.sink  cfg_chan
);

  srs_pkg::in_item_t item;
  srs_pkg::result_t  res;
  srs_pkg::result_t  out_r;
  srs_pkg::result_t  skid_r;
  logic              out_valid_r;
  logic              skid_valid_r;
  logic              in_fire;
  logic              out_free;

  // The input is held back only while an item is parked in the skid register.
  assign in_chan.ready  = !skid_valid_r;
  assign cfg_chan.ready = 1'b1;
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign out_free       = !out_valid_r || out_chan.ready;

  assign item.op         = in_chan.op;
  assign item.is_read    = in_chan.is_read;
  assign item.byte_count = in_chan.byte_count;
  assign item.reg_addr   = in_chan.reg_addr;
  assign item.wr_data    = in_chan.wr_data;
  assign item.rx_byte    = in_chan.rx_byte;

  // All per-event work happens in the core, between the input and the result register.
  srs_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_fire),
    .item       (item),
    .cfg_we     (cfg_chan.valid),
    .cfg_data   (cfg_chan.data),
    .res        (res)
  );

  // Result register with a skid stage. When the result register is free it loads the
  // skid item first if one is waiting, otherwise the fresh result; when it is stalled a
  // fresh result is parked in the skid register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (in_fire) begin
      skid_r <= res;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.tx_valid  = out_r.tx_valid;
  assign out_chan.tx_byte   = out_r.tx_byte;
  assign out_chan.done_res  = out_r.done_res;
  assign out_chan.read_data = out_r.read_data;
  assign out_chan.busy_res  = out_r.busy_res;
  assign out_chan.status    = out_r.status;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds an item while the result register is empty");

  a_stall_parks_item: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready && in_fire) |=> (skid_valid_r && out_valid_r))
    else $error("item accepted during an output stall was not parked");

endmodule

`default_nettype wire
